// ----- hdl/e2ewsm_pkg.sv -----
`timescale 1ns / 1ps

package e2ewsm_pkg;

    // window depth default and field widths
    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int SIZE_W           = 6;
    localparam int LIMIT_W          = 16;
    localparam int PS_W             = 3;
    localparam int TALLY_W          = 6;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    // machine states
    localparam logic [2:0] ST_DEINIT  = 3'd0;
    localparam logic [2:0] ST_NODATA  = 3'd1;
    localparam logic [2:0] ST_INIT    = 3'd2;
    localparam logic [2:0] ST_VALID   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // profile check status codes
    localparam logic [PS_W-1:0] PS_OK        = 3'd0;
    localparam logic [PS_W-1:0] PS_ERROR     = 3'd3;
    localparam logic [PS_W-1:0] PS_NOTAVAIL  = 3'd4;
    localparam logic [PS_W-1:0] PS_NONEWDATA = 3'd5;
    localparam logic [PS_W-1:0] PS_MAX       = 3'h5;

    // result codes
    localparam logic [1:0] RC_OK    = 2'd0;
    localparam logic [1:0] RC_RANGE = 2'd1;
    localparam logic [1:0] RC_STATE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WS_VALID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WS_INIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WS_INVALID = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_INIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_VALID  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_INV    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_INV  = 3'd6;

    typedef struct packed {
        logic            action;
        logic [PS_W-1:0] profile_status;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         result_code;
        logic [2:0]         machine_state;
        logic [TALLY_W-1:0] ok_total;
        logic [TALLY_W-1:0] error_total;
    } t_out_word;

endpackage

// ----- hdl/e2ewsm_ram.sv -----
`timescale 1ns / 1ps

module e2ewsm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/e2e_window_state_machine.sv -----
`timescale 1ns / 1ps

// E2E window state machine. Each input word is either an init command or one
// profile check status; each gives exactly one output word with the result
// code, the machine state after the step and the OK / ERROR counts of the
// current window. Statuses live in a single-port-write, registered-read RAM;
// a flag per entry marks it written, so an unwritten or cleared entry reads
// as not-available and no clearing pass is needed after reset. A status
// taken in init, valid or invalid is written, then the window is recounted
// by reading one entry per cycle, bounded by the RAM read port: such a word
// goes through the count, tail, eval and fin states before its output word
// is registered, and the next word is taken once the block is back in idle.
// Init commands, rejected statuses and nodata / deinit steps go from idle
// straight to the fin state. One word is worked on at a time; a finished
// output word waits in its register while the next input word is taken.
module e2e_window_state_machine #(
    parameter int WINDOW_DEPTH = e2ewsm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  e2ewsm_pkg::t_in_word                    i_in_word,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output e2ewsm_pkg::t_out_word                   o_out_word,
    input  logic                                    i_cfg_we,
    input  logic [e2ewsm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [e2ewsm_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = (AW > e2ewsm_pkg::SIZE_W) ? AW : e2ewsm_pkg::SIZE_W;
    localparam int TW = e2ewsm_pkg::TALLY_W;
    localparam int PW = e2ewsm_pkg::PS_W;
    localparam int LW = e2ewsm_pkg::LIMIT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COUNT = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // configuration
    logic [e2ewsm_pkg::SIZE_W-1:0] r_ws_valid, r_ws_init, r_ws_inv;
    logic [LW-1:0]                 r_lim_init, r_lim_valid, r_lim_inv;
    logic                          r_clr_inv;

    // control and machine state
    logic [2:0]              r_state, n_state;
    logic [2:0]              r_mode, n_mode;
    logic [AW-1:0]           r_slot, n_slot;
    logic [TW-1:0]           r_ok, n_ok;
    logic [TW-1:0]           r_err, n_err;
    logic [WINDOW_DEPTH-1:0] r_valid, n_valid;
    logic                    r_rd_pend, n_rd_pend;
    logic                    r_out_valid, n_out_valid;

    // working registers
    logic [AW-1:0]                r_idx, n_idx;
    logic [AW-1:0]                r_rd_addr, n_rd_addr;
    logic [TW-1:0]                r_cnt_ok, n_cnt_ok;
    logic [TW-1:0]                r_cnt_err, n_cnt_err;
    logic [CW-1:0]                r_size, n_size;
    logic [1:0]                   r_code, n_code;
    e2ewsm_pkg::t_out_word        r_out_word, n_out_word;

    logic          in_acc;
    logic [CW-1:0] sz_valid, sz_init, sz_inv, cur_size;
    logic [AW-1:0] slot_w, slot_nx;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [PW-1:0] ram_rdata;
    logic [PW-1:0] entry;
    logic          clr_en, set_en;
    logic [CW-1:0] clr_lo, clr_hi;
    logic          win_init, win_valid, win_inv;

    function automatic logic [CW-1:0] clamp_size(input logic [e2ewsm_pkg::SIZE_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (CW'(v) > CW'(WINDOW_DEPTH)) begin
            res = CW'(WINDOW_DEPTH);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    assign sz_valid = clamp_size(r_ws_valid);
    assign sz_init  = clamp_size(r_ws_init);
    assign sz_inv   = clamp_size(r_ws_inv);
    assign cur_size = (r_mode == e2ewsm_pkg::ST_VALID) ? sz_valid :
                      (r_mode == e2ewsm_pkg::ST_INIT)  ? sz_init  : sz_inv;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    // stale slot wraps before the write
    assign slot_w  = (CW'(r_slot) >= cur_size) ? '0 : r_slot;
    assign slot_nx = ((CW'(slot_w) + CW'(1)) >= cur_size) ? '0 : slot_w + AW'(1);

    // an entry without its written flag reads as not-available
    assign entry = r_valid[r_rd_addr] ? ram_rdata : e2ewsm_pkg::PS_NOTAVAIL;

    assign win_init  = (8'(r_cnt_err) <= r_lim_init[7:0]) && (8'(r_cnt_ok) >= r_lim_init[15:8]);
    assign win_valid = (8'(r_cnt_err) <= r_lim_valid[7:0]) && (8'(r_cnt_ok) >= r_lim_valid[15:8]);
    assign win_inv   = (8'(r_cnt_err) <= r_lim_inv[7:0]) && (8'(r_cnt_ok) >= r_lim_inv[15:8]);

    e2ewsm_ram #(
        .WIDTH (PW),
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_w),
        .i_wdata (i_in_word.profile_status),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_slot      = r_slot;
        n_ok        = r_ok;
        n_err       = r_err;
        n_idx       = r_idx;
        n_rd_addr   = r_idx;
        n_rd_pend   = 1'b0;
        n_cnt_ok    = r_cnt_ok;
        n_cnt_err   = r_cnt_err;
        n_size      = r_size;
        n_code      = r_code;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_raddr   = r_idx;
        clr_en      = 1'b0;
        clr_lo      = '0;
        clr_hi      = '0;
        set_en      = 1'b0;

        if (r_rd_pend) begin
            if (entry == e2ewsm_pkg::PS_OK) begin
                n_cnt_ok = r_cnt_ok + TW'(1);
            end
            if (entry == e2ewsm_pkg::PS_ERROR) begin
                n_cnt_err = r_cnt_err + TW'(1);
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_size  = cur_size;
                    n_code  = e2ewsm_pkg::RC_OK;
                    n_state = S_FIN;
                    if (i_in_word.action) begin
                        clr_en = 1'b1;
                        clr_hi = cur_size;
                        n_ok   = '0;
                        n_err  = '0;
                        n_slot = '0;
                        n_mode = e2ewsm_pkg::ST_NODATA;
                    end else if (i_in_word.profile_status > e2ewsm_pkg::PS_MAX) begin
                        n_code = e2ewsm_pkg::RC_RANGE;
                    end else begin
                        case (r_mode)
                            e2ewsm_pkg::ST_NODATA: begin
                                if (i_in_word.profile_status != e2ewsm_pkg::PS_ERROR &&
                                    i_in_word.profile_status != e2ewsm_pkg::PS_NONEWDATA) begin
                                    n_mode = e2ewsm_pkg::ST_INIT;
                                end
                            end
                            e2ewsm_pkg::ST_INIT, e2ewsm_pkg::ST_VALID,
                            e2ewsm_pkg::ST_INVALID: begin
                                ram_we    = 1'b1;
                                set_en    = 1'b1;
                                n_slot    = slot_nx;
                                n_idx     = '0;
                                n_cnt_ok  = '0;
                                n_cnt_err = '0;
                                n_state   = S_COUNT;
                            end
                            default: begin
                                n_code = e2ewsm_pkg::RC_STATE;
                            end
                        endcase
                    end
                end
            end
            S_COUNT: begin
                // one window entry read per cycle
                n_rd_pend = 1'b1;
                n_idx     = r_idx + AW'(1);
                if (CW'(r_idx) == r_size - CW'(1)) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_ok    = r_cnt_ok;
                n_err   = r_cnt_err;
                n_state = S_FIN;
                case (r_mode)
                    e2ewsm_pkg::ST_INIT: begin
                        if (win_init) begin
                            clr_en = 1'b1;
                            clr_lo = r_size;
                            clr_hi = sz_valid;
                            n_mode = e2ewsm_pkg::ST_VALID;
                        end else if (8'(r_cnt_err) > r_lim_init[7:0]) begin
                            clr_en = 1'b1;
                            if (r_clr_inv) begin
                                clr_hi = r_size;
                                n_ok   = '0;
                                n_err  = '0;
                                n_slot = '0;
                            end else begin
                                clr_lo = r_size;
                                clr_hi = sz_inv;
                            end
                            n_mode = e2ewsm_pkg::ST_INVALID;
                        end
                    end
                    e2ewsm_pkg::ST_VALID: begin
                        if (!win_valid) begin
                            if (r_clr_inv) begin
                                clr_en = 1'b1;
                                clr_hi = r_size;
                                n_ok   = '0;
                                n_err  = '0;
                                n_slot = '0;
                            end
                            n_mode = e2ewsm_pkg::ST_INVALID;
                        end
                    end
                    e2ewsm_pkg::ST_INVALID: begin
                        if (win_inv) begin
                            clr_en = 1'b1;
                            clr_lo = r_size;
                            clr_hi = sz_valid;
                            n_mode = e2ewsm_pkg::ST_VALID;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid                = 1'b1;
                    n_out_word.result_code     = r_code;
                    n_out_word.machine_state   = r_mode;
                    n_out_word.ok_total        = r_ok;
                    n_out_word.error_total     = r_err;
                    n_state                    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // written flags: range clear and single set
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            n_valid[i] = r_valid[i];
            if (clr_en && CW'(i) >= clr_lo && CW'(i) < clr_hi) begin
                n_valid[i] = 1'b0;
            end
            if (set_en && CW'(i) == CW'(slot_w)) begin
                n_valid[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= e2ewsm_pkg::ST_DEINIT;
            r_slot      <= '0;
            r_ok        <= '0;
            r_err       <= '0;
            r_valid     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_slot      <= n_slot;
            r_ok        <= n_ok;
            r_err       <= n_err;
            r_valid     <= n_valid;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_addr  <= n_rd_addr;
        r_cnt_ok   <= n_cnt_ok;
        r_cnt_err  <= n_cnt_err;
        r_size     <= n_size;
        r_code     <= n_code;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws_valid  <= e2ewsm_pkg::SIZE_W'(1);
            r_ws_init   <= e2ewsm_pkg::SIZE_W'(1);
            r_ws_inv    <= e2ewsm_pkg::SIZE_W'(1);
            r_lim_init  <= '0;
            r_lim_valid <= '0;
            r_lim_inv   <= '0;
            r_clr_inv   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                e2ewsm_pkg::REG_WS_VALID:   r_ws_valid  <= i_cfg_wdata[e2ewsm_pkg::SIZE_W-1:0];
                e2ewsm_pkg::REG_WS_INIT:    r_ws_init   <= i_cfg_wdata[e2ewsm_pkg::SIZE_W-1:0];
                e2ewsm_pkg::REG_WS_INVALID: r_ws_inv    <= i_cfg_wdata[e2ewsm_pkg::SIZE_W-1:0];
                e2ewsm_pkg::REG_LIM_INIT:   r_lim_init  <= i_cfg_wdata[LW-1:0];
                e2ewsm_pkg::REG_LIM_VALID:  r_lim_valid <= i_cfg_wdata[LW-1:0];
                e2ewsm_pkg::REG_LIM_INV:    r_lim_inv   <= i_cfg_wdata[LW-1:0];
                e2ewsm_pkg::REG_CLEAR_INV:  r_clr_inv   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- hdl/e2ewsm_chk.sv -----
`timescale 1ns / 1ps

module e2ewsm_chk #(
    parameter int WINDOW_DEPTH = e2ewsm_pkg::WINDOW_DEPTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input e2ewsm_pkg::t_in_word              i_in_word,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input e2ewsm_pkg::t_out_word             o_out_word,
    input logic                              i_cfg_we,
    input logic [e2ewsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [e2ewsm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int MAX_WIN = (WINDOW_DEPTH < 63) ? WINDOW_DEPTH : 63;

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // both counts come from one window
    a_tally_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ({1'b0, o_out_word.ok_total} + {1'b0, o_out_word.error_total}) <= 7'(MAX_WIN))
        else $error("ok and error counts exceed the window");

    // wrong state is only reported from deinit
    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.result_code == e2ewsm_pkg::RC_STATE |->
        o_out_word.machine_state == e2ewsm_pkg::ST_DEINIT)
        else $error("wrong state code outside deinit");

    // no window counts before the machine leaves nodata
    a_empty_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.machine_state == e2ewsm_pkg::ST_DEINIT ||
                        o_out_word.machine_state == e2ewsm_pkg::ST_NODATA) |->
        o_out_word.ok_total == '0 && o_out_word.error_total == '0)
        else $error("counts nonzero in deinit or nodata");

    // reset leaves the block ready with no output word
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind e2e_window_state_machine e2ewsm_chk #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_e2ewsm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_wdata (i_cfg_wdata)
);

// ----- tb/sv/e2e_window_state_machine_tb.sv -----
`timescale 1ns / 1ps

module e2e_window_state_machine_tb;
    import e2ewsm_pkg::*;

    localparam int DEPTH      = WINDOW_DEPTH_DEF;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_WAIT = 40;

    localparam logic [PS_W-1:0] PS_REPEATED = 3'd1;
    localparam logic [PS_W-1:0] PS_WRONGSEQ = 3'd2;
    localparam logic [PS_W-1:0] PS_BAD_LO   = PS_MAX + 3'd1;
    localparam logic [PS_W-1:0] PS_BAD_HI   = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // shadow copy of the registers
    logic [SIZE_W-1:0]  len_valid, len_init, len_invalid;
    logic [LIMIT_W-1:0] lim_init, lim_valid, lim_invalid;
    logic               clr_inv;

    // predicted machine state
    logic [2:0]      fsm_mode;
    logic [PS_W-1:0] hist [DEPTH];
    int              hist_slot, ok_cnt, err_cnt;

    t_out_word reports_due[$];
    bit        gaps_on = 1'b1;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    e2e_window_state_machine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_shadow();
        len_valid   = SIZE_W'(1);
        len_init    = SIZE_W'(1);
        len_invalid = SIZE_W'(1);
        lim_init    = '0;
        lim_valid   = '0;
        lim_invalid = '0;
        clr_inv     = 1'b0;
        fsm_mode    = ST_DEINIT;
        for (int i = 0; i < DEPTH; i++) hist[i] = PS_NOTAVAIL;
        hist_slot = 0;
        ok_cnt    = 0;
        err_cnt   = 0;
    endfunction

    function automatic int window_len(logic [2:0] st);
        int raw;
        if (st == ST_VALID) raw = len_valid;
        else if (st == ST_INIT) raw = len_init;
        else raw = len_invalid;
        if (raw == 0) return 1;
        if (raw > DEPTH) return DEPTH;
        return raw;
    endfunction

    function automatic void mark_unavail(int from, int upto);
        for (int i = from; i < upto && i < DEPTH; i++) hist[i] = PS_NOTAVAIL;
    endfunction

    function automatic void push_status(logic [PS_W-1:0] ps);
        int len;
        len = window_len(fsm_mode);
        // a shorter window can leave the slot past its end
        if (hist_slot >= len) hist_slot = 0;
        hist[hist_slot] = ps;
        ok_cnt  = 0;
        err_cnt = 0;
        for (int i = 0; i < len; i++) begin
            if (hist[i] == PS_OK) ok_cnt++;
            if (hist[i] == PS_ERROR) err_cnt++;
        end
        hist_slot = (hist_slot + 1 >= len) ? 0 : hist_slot + 1;
    endfunction

    function automatic void wipe_window();
        mark_unavail(0, window_len(fsm_mode));
        ok_cnt    = 0;
        err_cnt   = 0;
        hist_slot = 0;
    endfunction

    function automatic void widen_for(logic [2:0] next_st);
        int cur, nxt;
        cur = window_len(fsm_mode);
        nxt = window_len(next_st);
        if (cur < nxt) mark_unavail(cur, nxt);
    endfunction

    function automatic bit in_limits(logic [LIMIT_W-1:0] lim);
        return (err_cnt <= int'(lim[7:0])) && (ok_cnt >= int'(lim[15:8]));
    endfunction

    function automatic t_out_word step_window_fsm(t_in_word w);
        t_out_word r;
        r.result_code = RC_OK;
        if (w.action) begin
            wipe_window();
            fsm_mode = ST_NODATA;
        end else if (w.profile_status > PS_MAX) begin
            r.result_code = RC_RANGE;
        end else begin
            case (fsm_mode)
                ST_NODATA: begin
                    if (w.profile_status != PS_ERROR && w.profile_status != PS_NONEWDATA)
                        fsm_mode = ST_INIT;
                end
                ST_INIT: begin
                    push_status(w.profile_status);
                    if (in_limits(lim_init)) begin
                        widen_for(ST_VALID);
                        fsm_mode = ST_VALID;
                    end else if (err_cnt > int'(lim_init[7:0])) begin
                        if (clr_inv) wipe_window();
                        else widen_for(ST_INVALID);
                        fsm_mode = ST_INVALID;
                    end
                end
                ST_VALID: begin
                    push_status(w.profile_status);
                    // valid to invalid never widens the window
                    if (!in_limits(lim_valid)) begin
                        if (clr_inv) wipe_window();
                        fsm_mode = ST_INVALID;
                    end
                end
                ST_INVALID: begin
                    push_status(w.profile_status);
                    if (in_limits(lim_invalid)) begin
                        widen_for(ST_VALID);
                        fsm_mode = ST_VALID;
                    end
                end
                default: r.result_code = RC_STATE;
            endcase
        end
        r.machine_state = fsm_mode;
        r.ok_total      = TALLY_W'(ok_cnt);
        r.error_total   = TALLY_W'(err_cnt);
        return r;
    endfunction

    task automatic send_word(input logic act, input logic [PS_W-1:0] ps);
        t_in_word w;
        int       gap;
        bit       taken;
        w.action         = act;
        w.profile_status = ps;
        gap = 0;
        if (gaps_on && $urandom_range(3) == 0) gap = $urandom_range(19, 1);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
        reports_due.push_back(step_window_fsm(w));
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (reports_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_WS_VALID:   len_valid   = val[SIZE_W-1:0];
            REG_WS_INIT:    len_init    = val[SIZE_W-1:0];
            REG_WS_INVALID: len_invalid = val[SIZE_W-1:0];
            REG_LIM_INIT:   lim_init    = val[LIMIT_W-1:0];
            REG_LIM_VALID:  lim_valid   = val[LIMIT_W-1:0];
            REG_LIM_INV:    lim_invalid = val[LIMIT_W-1:0];
            REG_CLEAR_INV:  clr_inv     = val[0];
            default: ;
        endcase
    endtask

    function automatic int unsigned pick_len();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(63, 33);
        if (r == 2) return DEPTH;
        return $urandom_range(8, 1);
    endfunction

    // thresholds mostly within reach of the window they apply to
    function automatic int unsigned pick_limits(int len);
        int r;
        r = $urandom_range(7);
        if (r == 0) return 16'hFFFF;
        if (r == 1) return 16'h0000;
        if (r == 2) return $urandom_range(16'hFFFF);
        return ($urandom_range(len) << 8) | $urandom_range(len / 2);
    endfunction

    task automatic test_defaults_and_rejects();
        send_word(1'b0, PS_OK);        // deinit refuses a check
        send_word(1'b0, PS_BAD_HI);    // out of range wins over the state
        send_word(1'b1, PS_BAD_LO);    // init ignores the status field
        send_word(1'b0, PS_ERROR);
        send_word(1'b0, PS_NONEWDATA);
        send_word(1'b0, PS_WRONGSEQ);  // nodata to init
        send_word(1'b0, PS_OK);
        send_word(1'b0, PS_ERROR);
        send_word(1'b0, PS_NOTAVAIL);
        hold_input();
        wait_drain();
    endtask

    task automatic test_window_resize();
        write_reg(REG_WS_VALID, 63);
        write_reg(REG_WS_INIT, 0);
        write_reg(REG_WS_INVALID, 3);
        write_reg(REG_LIM_INIT, 16'h0100);
        write_reg(REG_LIM_VALID, 16'h0003);
        write_reg(REG_LIM_INV, 16'h0201);
        write_reg(REG_CLEAR_INV, 0);
        send_word(1'b1, PS_OK);
        send_word(1'b0, PS_NOTAVAIL);
        send_word(1'b0, PS_REPEATED);
        send_word(1'b0, PS_OK);         // init to valid grows the window to full depth
        send_word(1'b0, PS_OK);
        send_word(1'b0, PS_WRONGSEQ);
        send_word(1'b0, PS_NONEWDATA);
        repeat (4) send_word(1'b0, PS_ERROR);
        // slot sits past the short invalid window here
        send_word(1'b0, PS_OK);
        send_word(1'b0, PS_OK);
        hold_input();
        wait_drain();
    endtask

    task automatic test_clear_on_invalid();
        write_reg(REG_CLEAR_INV, 1);
        write_reg(REG_LIM_VALID, 16'h0000);
        send_word(1'b1, PS_ERROR);
        send_word(1'b0, PS_OK);
        send_word(1'b0, PS_OK);
        send_word(1'b0, PS_ERROR);
        hold_input();
        wait_drain();
    endtask

    task automatic test_random_phases();
        int r, err_pct;
        for (int p = 0; p < 10; p++) begin
            if (p >= 8) gaps_on = 1'b0;
            if (p == 0) begin
                write_reg(REG_WS_VALID, DEPTH);
                write_reg(REG_WS_INIT, DEPTH);
                write_reg(REG_WS_INVALID, DEPTH);
            end else if (p == 1) begin
                write_reg(REG_WS_VALID, 0);
                write_reg(REG_WS_INIT, 0);
                write_reg(REG_WS_INVALID, 0);
            end else begin
                write_reg(REG_WS_VALID, pick_len());
                write_reg(REG_WS_INIT, pick_len());
                write_reg(REG_WS_INVALID, pick_len());
            end
            write_reg(REG_LIM_INIT, pick_limits(window_len(ST_INIT)));
            write_reg(REG_LIM_VALID, pick_limits(window_len(ST_VALID)));
            write_reg(REG_LIM_INV, pick_limits(window_len(ST_INVALID)));
            write_reg(REG_CLEAR_INV, $urandom_range(1));
            err_pct = $urandom_range(50, 10);
            send_word(1'b1, PS_W'($urandom_range(7)));
            for (int k = 0; k < 57; k++) begin
                r = $urandom_range(99);
                if (r < 3) send_word(1'b1, PS_W'($urandom_range(7)));
                else if (r < 7) send_word(1'b0, PS_W'($urandom_range(7, 6)));
                else if ($urandom_range(99) < err_pct) send_word(1'b0, PS_ERROR);
                else if ($urandom_range(3) != 0) send_word(1'b0, PS_OK);
                else send_word(1'b0, PS_W'($urandom_range(5)));
            end
            hold_input();
            wait_drain();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reports_due.size() == 0) begin
                $error("output word with nothing expected: %h", o_out_word);
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("result_code", want.result_code, o_out_word.result_code);
                check_field("machine_state", want.machine_state, o_out_word.machine_state);
                check_field("ok_total", want.ok_total, o_out_word.ok_total);
                check_field("error_total", want.error_total, o_out_word.error_total);
            end
        end
    end

    // receiver stall bursts, quiet stretches in between
    initial begin
        int burst, calm;
        burst = 0;
        calm  = 0;
        forever begin
            @(negedge i_clk);
            if (!gaps_on) begin
                i_out_stall = 1'b0;
            end else begin
                if (burst == 0 && calm == 0) begin
                    calm  = $urandom_range(40);
                    burst = $urandom_range(19, 1);
                end
                if (calm > 0) begin
                    i_out_stall = 1'b0;
                    calm--;
                end else begin
                    i_out_stall = 1'b1;
                    burst--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        reset_shadow();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_defaults_and_rejects();
        test_window_resize();
        test_clear_on_invalid();
        test_random_phases();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/e2ewsm_pkg.sv
hdl/e2ewsm_ram.sv
hdl/e2e_window_state_machine.sv
hdl/e2ewsm_chk.sv
tb/sv/e2e_window_state_machine_tb.sv
